### hdl/mtke_pkg.sv
package mtke_pkg;

    // operation codes
    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_COMMIT  = 2'd2;

    // shift modes that raise letters to upper case
    localparam logic [1:0] SHIFT_TITLE = 2'd1;
    localparam logic [1:0] SHIFT_UPPER = 2'd2;

    localparam int NUM_KEYS = 10;
    localparam int MAX_SEQ  = 8;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // character list per key, unused slots zero
    localparam logic [7:0] KEY_CHARS [NUM_KEYS][MAX_SEQ] = '{
        '{8'h20, "0", 8'h0a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{".", ",", "?", "!", 8'h27, "@", "#", "1"},
        '{"a", "b", "c", "2", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "e", "f", "3", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"g", "h", "i", "4", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"j", "k", "l", "5", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "n", "o", "6", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "q", "r", "s", "7", 8'h00, 8'h00, 8'h00},
        '{"t", "u", "v", "8", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "x", "y", "z", "9", 8'h00, 8'h00, 8'h00}
    };

    // number of characters per key
    localparam logic [3:0] KEY_LENS [NUM_KEYS] = '{
        4'd3, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd5
    };

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  key_digit;
        logic [63:0] time_ms;
        logic [1:0]  shift_mode;
    } item_t;

    typedef struct packed {
        logic [7:0] shown_char;
        logic       committed_flag;
        logic [7:0] committed_char;
    } result_t;

    typedef struct packed {
        logic       key_active;
        logic [3:0] active_key;
        logic [2:0] cycle_position;
    } status_t;

endpackage

### hdl/mtke_in_stage.sv
module mtke_in_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // key_digit[3:0], time_ms[67:4], shift_mode[69:68], zero fill
    input  logic [mtke_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation[1:0]
    input  logic [mtke_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                              advance,
    output logic                              item_valid,
    output mtke_pkg::item_t                   item
);
    import mtke_pkg::*;

    logic  in_valid_reg, in_valid_next;
    item_t item_reg;
    logic  s_accept;

    // the stage frees up whenever the item moves on
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // unpack the item
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.operation  <= s_tuser[1:0];
            item_reg.key_digit  <= s_tdata[3:0];
            item_reg.time_ms    <= s_tdata[67:4];
            item_reg.shift_mode <= s_tdata[69:68];
        end
    end

    assign item_valid = in_valid_reg;
    assign item       = item_reg;

endmodule

### hdl/mtke_core.sv
module mtke_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_data,
    input  logic              fire,
    input  mtke_pkg::item_t   item,
    output mtke_pkg::result_t result,
    output mtke_pkg::status_t status
);
    import mtke_pkg::*;

    logic [31:0] timeout_reg;
    logic        key_active_reg, key_active_next;
    logic [3:0]  active_key_reg, active_key_next;
    logic [2:0]  pos_reg, pos_next;
    logic [63:0] last_time_reg, last_time_next;
    logic [7:0]  pending_reg, pending_next;

    logic        digit_ok;
    logic [3:0]  key_len;
    logic [3:0]  pos_inc;
    logic [2:0]  press_pos;
    logic [7:0]  raw_char;
    logic [7:0]  new_char;
    logic        upper;
    logic [63:0] elapsed;
    logic        timed_out;

    assign digit_ok = item.key_digit < 4'(NUM_KEYS);
    assign key_len  = KEY_LENS[item.key_digit];
    assign pos_inc  = {1'b0, pos_reg} + 4'd1;
    assign elapsed  = item.time_ms - last_time_reg;
    assign timed_out = elapsed >= {32'd0, timeout_reg};
    assign upper    = (item.shift_mode == SHIFT_TITLE) || (item.shift_mode == SHIFT_UPPER);

    // position after a press: step on the same key, else start over
    assign press_pos = (key_active_reg && active_key_reg == item.key_digit) ?
                       ((pos_inc == key_len) ? 3'd0 : pos_inc[2:0]) : 3'd0;

    // character lookup at the new position, with shift applied to letters
    assign raw_char = KEY_CHARS[item.key_digit][press_pos];
    assign new_char = (upper && raw_char >= "a" && raw_char <= "z") ?
                      raw_char - 8'h20 : raw_char;

    // next state and result for the current item
    always_comb begin
        key_active_next = key_active_reg;
        active_key_next = active_key_reg;
        pos_next        = pos_reg;
        last_time_next  = last_time_reg;
        pending_next    = pending_reg;
        result          = '0;
        case (item.operation)
            OP_PRESS: begin
                if (digit_ok) begin
                    if (key_active_reg && active_key_reg != item.key_digit) begin
                        result.committed_flag = 1'b1;
                        result.committed_char = pending_reg;
                    end
                    pos_next          = press_pos;
                    key_active_next   = 1'b1;
                    active_key_next   = item.key_digit;
                    last_time_next    = item.time_ms;
                    pending_next      = new_char;
                    result.shown_char = new_char;
                end
            end
            OP_TIMEOUT, OP_COMMIT: begin
                if (key_active_reg && (item.operation == OP_COMMIT || timed_out)) begin
                    result.committed_flag = 1'b1;
                    result.committed_char = pending_reg;
                    key_active_next = 1'b0;
                    active_key_next = 4'd0;
                    pos_next        = 3'd0;
                    last_time_next  = 64'd0;
                    pending_next    = 8'd0;
                end
            end
            default: begin
            end
        endcase
    end

    // entry state and timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= TIMEOUT_RESET;
            key_active_reg <= 1'b0;
            active_key_reg <= 4'd0;
            pos_reg        <= 3'd0;
            last_time_reg  <= 64'd0;
            pending_reg    <= 8'd0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_data;
            end
            if (fire) begin
                key_active_reg <= key_active_next;
                active_key_reg <= active_key_next;
                pos_reg        <= pos_next;
                last_time_reg  <= last_time_next;
                pending_reg    <= pending_next;
            end
        end
    end

    assign status.key_active     = key_active_reg;
    assign status.active_key     = active_key_reg;
    assign status.cycle_position = pos_reg;

endmodule

### hdl/mtke_out_stage.sv
module mtke_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           res_valid,
    input  mtke_pkg::result_t              result,
    output logic                           advance,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // shown_char[7:0], committed_char[15:8]
    output logic [mtke_pkg::M_TDATA_W-1:0] m_tdata,
    // committed_flag
    output logic                           m_tuser
);
    import mtke_pkg::*;

    logic    out_valid_reg;
    result_t result_reg;

    // result register takes a new item when empty or being drained
    assign advance = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    // pack the result
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.committed_char, result_reg.shown_char};
    assign m_tuser  = result_reg.committed_flag;

endmodule

### hdl/multi_tap_keypad_entry.sv
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless m_tready stalls the result register;
// each register holds one item, and the entry state updates as an item moves on.
// Reset: aresetn is synchronous, active low; it empties both registers,
// clears the pending character and sets timeout_ms to 1000.
module multi_tap_keypad_entry (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key_digit[3:0], time_ms[67:4], shift_mode[69:68], zero fill
    input  logic [mtke_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [mtke_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // shown_char[7:0], committed_char[15:8]
    output logic [mtke_pkg::M_TDATA_W-1:0] m_tdata,
    // committed_flag
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [31:0]                    cfg_data
);
    import mtke_pkg::*;

    logic    advance;
    logic    item_valid;
    item_t   item;
    result_t result;
    status_t status;
    logic    fire;

    assign cfg_ready = 1'b1;
    assign fire      = item_valid && advance;

    // input register
    mtke_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // entry state and per item logic
    mtke_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .fire     (fire),
        .item     (item),
        .result   (result),
        .status   (status)
    );

    // result register
    mtke_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .result    (result),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef ASSERT_OFF
    // no committed character without the commit flag
    a_commit_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[15:8] == 8'd0)
        else $error("committed char set without commit flag");

    // a cleared entry keeps key and position at zero
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.key_active |-> status.active_key == 4'd0 && status.cycle_position == 3'd0)
        else $error("entry state not cleared while no key pending");

    // position stays within the active key's list
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        status.key_active |-> status.active_key < 4'(NUM_KEYS) &&
            {1'b0, status.cycle_position} < KEY_LENS[status.active_key])
        else $error("cycle position out of range");
`endif

endmodule
